// ===== design/hga_pkg.sv =====
package hga_pkg;

	// Field widths fixed by the item formats
	localparam int CRD_W = 32;
	localparam int ACC_W = 48;
	localparam int IDX_W = 3;

	// Internal datapath widths
	localparam int AD_W   = 32;              // |center - pos| stays below 2^32
	localparam int SQ_W   = 2 * AD_W;        // one squared component
	localparam int SUM_W  = SQ_W + 2;        // sum of three squares
	localparam int R_W    = AD_W + 1;        // integer root of the sum
	localparam int S_W    = R_W + 1;         // r + scale radius
	localparam int RS_W   = R_W + S_W;       // r * s
	localparam int RS_LO_W = S_W;            // low slice of r * s for the split product
	localparam int DEN_W  = RS_W + S_W;      // r * s * s
	localparam int GAD_W  = CRD_W + AD_W;    // gm * |d|
	localparam int P_W    = 2 * CRD_W;       // tick * interval

	// Saturation limits of the 48-bit result
	localparam logic [ACC_W-1:0] ACC_POS_LIM = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_NEG_LIM = {1'b1, {(ACC_W-1){1'b0}}};

	// Register reset values
	localparam logic [CRD_W-1:0] CENTER_RESET = 32'd0;
	localparam logic [CRD_W-1:0] GM_RESET     = 32'd47914726;
	localparam logic [CRD_W-1:0] SCALE_RESET  = 32'd655;
	localparam logic [CRD_W-1:0] TBASE_RESET  = 32'd0;
	localparam logic [CRD_W-1:0] RAMP_RESET   = 32'd65536;

	typedef enum logic [IDX_W-1:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_CENTER_Z,
		REG_GM_PRODUCT,
		REG_SCALE_RADIUS,
		REG_TIMEBASE_INTERVAL,
		REG_RAMP_TIME
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_UNSCALED,
		MODE_GROW,
		MODE_RELEASE
	} mode_t;

	typedef struct packed {
		logic [1:0]              mode;
		logic signed [CRD_W-1:0] pos_x;
		logic signed [CRD_W-1:0] pos_y;
		logic signed [CRD_W-1:0] pos_z;
		logic [CRD_W-1:0]        current_tick;
	} in_item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] accel_x;
		logic signed [ACC_W-1:0] accel_y;
		logic signed [ACC_W-1:0] accel_z;
		logic                    zero_radius;
	} out_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [CRD_W-1:0] value;
	} cfg_item_t;

endpackage

// ===== design/hga_stream_if.sv =====
interface hga_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/hga_pipe_div.sv =====
module hga_pipe_div #(
	parameter int NUM_W = 16,
	parameter int DEN_W = 8,
	parameter int Q_W   = 8
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo
);
	// One quotient bit per stage, most significant first.
	// The caller guarantees num < den * 2^Q_W or discards the result.
	localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic [W-1:0]     rem_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [Q_W-1:0]   q_s   [Q_W];

	logic [W-1:0]     cur_rem [Q_W];
	logic [DEN_W-1:0] cur_den [Q_W];
	logic [Q_W-1:0]   cur_q   [Q_W];
	logic [W-1:0]     trial   [Q_W];
	logic [Q_W-1:0]   take;

	// Trial subtract of the shifted divisor in every stage
	always_comb begin
		cur_rem[0] = W'(num);
		cur_den[0] = den;
		cur_q[0]   = '0;
		for (int j = 1; j < Q_W; j++) begin
			cur_rem[j] = rem_s[j-1];
			cur_den[j] = den_s[j-1];
			cur_q[j]   = q_s[j-1];
		end
		for (int j = 0; j < Q_W; j++) begin
			trial[j] = W'(cur_den[j]) << (Q_W - 1 - j);
			take[j]  = cur_rem[j] >= trial[j];
		end
	end

	// Advance all stages together
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < Q_W; j++) begin
				rem_s[j] <= take[j] ? cur_rem[j] - trial[j] : cur_rem[j];
				den_s[j] <= cur_den[j];
				q_s[j]   <= cur_q[j] | (Q_W'(take[j]) << (Q_W - 1 - j));
			end
		end
	end

	assign quo = q_s[Q_W-1];
endmodule

// ===== design/hga_isqrt.sv =====
module hga_isqrt #(
	parameter int IN_W  = 66,
	parameter int OUT_W = 33
) (
	input  logic             clk,
	input  logic             en,
	input  logic [IN_W-1:0]  rad,
	output logic [OUT_W-1:0] root
);
	// Digit-by-digit root, one result bit per stage; remainder holds rad - root^2
	localparam int TW = (IN_W > 2 * OUT_W + 1) ? IN_W : 2 * OUT_W + 1;

	logic [TW-1:0]    rem_s [OUT_W];
	logic [OUT_W-1:0] res_s [OUT_W];

	logic [TW-1:0]    cur_rem [OUT_W];
	logic [OUT_W-1:0] cur_res [OUT_W];
	logic [TW-1:0]    trial   [OUT_W];
	logic [OUT_W-1:0] take;

	// Trial term (2*res + 2^b) * 2^b against the remainder
	always_comb begin
		cur_rem[0] = TW'(rad);
		cur_res[0] = '0;
		for (int j = 1; j < OUT_W; j++) begin
			cur_rem[j] = rem_s[j-1];
			cur_res[j] = res_s[j-1];
		end
		for (int j = 0; j < OUT_W; j++) begin
			trial[j] = (TW'(cur_res[j]) << (OUT_W - j)) |
				(TW'(1) << (2 * (OUT_W - 1 - j)));
			take[j]  = cur_rem[j] >= trial[j];
		end
	end

	// Advance all stages together
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < OUT_W; j++) begin
				rem_s[j] <= take[j] ? cur_rem[j] - trial[j] : cur_rem[j];
				res_s[j] <= cur_res[j] | (OUT_W'(take[j]) << (OUT_W - 1 - j));
			end
		end
	end

	assign root = res_s[OUT_W-1];
endmodule

// ===== design/hernquist_gravity_accel.sv =====
// Channel   Dir   Payload                                   Transfer
// pos_in    in    mode, pos_x/y/z, current_tick             valid & ready
// acc_out   out   accel_x/y/z, zero_radius                  valid & ready
// cfg       in    index (register 0..6), value              valid & ready
//
// One particle per cycle while the output buffer has room; the result path runs
// through the 33-stage root and the 48-stage dividers that run one bit per stage.
// Reset clears all stage valids, the two-entry output buffer and loads the
// registers with their reset values. The pipeline advances as a whole and
// halts only while both output buffer entries are occupied.
module hernquist_gravity_accel #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	hga_stream_if.sink    pos_in,
	hga_stream_if.source  acc_out,
	hga_stream_if.sink    cfg
);
	import hga_pkg::*;

	localparam int F      = FRAC_BITS;
	localparam int M_W    = F + 1;
	localparam int RN_W   = P_W + F;
	localparam int NUMP_W = GAD_W + M_W;
	localparam int NUM_W  = NUMP_W + F;
	localparam int DLO_W  = RS_LO_W + S_W;
	localparam int DHI_W  = RS_W - RS_LO_W + S_W;
	localparam int OVF_W  = DEN_W + ACC_W;
	localparam logic [M_W-1:0] FULL = M_W'(1) << F;

	// Stage numbers
	localparam int ST_IN  = 1;
	localparam int ST_SQ  = 2;
	localparam int ST_SUM = 3;
	localparam int ST_K   = ST_IN + F;
	localparam int ST_M   = ST_K + 1;
	localparam int ST_R   = ST_SUM + R_W;
	localparam int ST_DEN = ST_R + 4;
	localparam int ST_OVF = ST_DEN + 1;
	localparam int ST_Q   = ST_DEN + ACC_W;

	// Configuration registers
	logic [CRD_W-1:0] cen_q [3];
	logic [CRD_W-1:0] gm_q, scale_q, tbase_q, ramp_q;

	// Pipeline control
	logic             en, accept, push, pop;
	logic [ST_Q:ST_IN] vld_s;
	logic [1:0]       cnt_q;
	logic             rd_q, wr_q;
	out_item_t        fifo_q [2];
	out_item_t        res_item;

	// Pipeline payload
	logic [2:0]         neg_s [ST_IN:ST_Q];
	logic [1:0]         mode_s [ST_IN:ST_K];
	logic               elapsed_s [ST_SQ:ST_K];
	logic [AD_W-1:0]    ad_s1 [3];
	logic [P_W-1:0]     p_s1;
	logic [SQ_W-1:0]    sq_s2 [3];
	logic [GAD_W-1:0]   gad_s [ST_SQ:ST_R][3];
	logic [SUM_W-1:0]   sum_s3;
	logic               zero_s [ST_SUM:ST_Q];
	logic [M_W-1:0]     m_s [ST_M:ST_R];
	logic [R_W-1:0]     r_s37;
	logic [S_W-1:0]     s_s37, s_s38;
	logic [NUMP_W-1:0]  num_s37 [3];
	logic [NUMP_W-1:0]  num_s38 [3];
	logic [NUMP_W-1:0]  num_s39 [3];
	logic [NUMP_W-1:0]  num_s40 [3];
	logic [RS_W-1:0]    rs_s38;
	logic [DLO_W-1:0]   dlo_s39;
	logic [DHI_W-1:0]   dhi_s39;
	logic [DEN_W-1:0]   den_s40;
	logic [2:0]         ovf_s [ST_OVF:ST_Q];

	// Combinational values
	logic [CRD_W-1:0]   pos_w [3];
	logic [CRD_W:0]     d_w [3];
	logic [CRD_W:0]     nd_w [3];
	logic [F-1:0]       k_w;
	logic [M_W-1:0]     kk_w, m_w;
	logic [R_W-1:0]     r_w;
	logic [ACC_W-1:0]   q_w [3];
	logic [ACC_W-1:0]   acc_w [3];

	// Handshake: the pipeline runs unless the output buffer is full
	assign en           = (cnt_q != 2'd2);
	assign pos_in.ready = en;
	assign accept       = pos_in.valid && en;
	assign push         = vld_s[ST_Q] && en;
	assign pop          = acc_out.valid && acc_out.ready;
	assign cfg.ready    = 1'b1;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cen_q[0] <= CENTER_RESET;
			cen_q[1] <= CENTER_RESET;
			cen_q[2] <= CENTER_RESET;
			gm_q     <= GM_RESET;
			scale_q  <= SCALE_RESET;
			tbase_q  <= TBASE_RESET;
			ramp_q   <= RAMP_RESET;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.data.index))
				REG_CENTER_X:          cen_q[0] <= cfg.data.value;
				REG_CENTER_Y:          cen_q[1] <= cfg.data.value;
				REG_CENTER_Z:          cen_q[2] <= cfg.data.value;
				REG_GM_PRODUCT:        gm_q     <= cfg.data.value;
				REG_SCALE_RADIUS:      scale_q  <= cfg.data.value;
				REG_TIMEBASE_INTERVAL: tbase_q  <= cfg.data.value;
				REG_RAMP_TIME:         ramp_q   <= cfg.data.value;
				default: ;
			endcase
		end
	end

	// Offset from particle to center, sign and magnitude
	always_comb begin
		pos_w[0] = pos_in.data.pos_x;
		pos_w[1] = pos_in.data.pos_y;
		pos_w[2] = pos_in.data.pos_z;
		for (int i = 0; i < 3; i++) begin
			d_w[i]  = {cen_q[i][CRD_W-1], cen_q[i]} - {pos_w[i][CRD_W-1], pos_w[i]};
			nd_w[i] = -d_w[i];
		end
	end

	// Ramp factor from the divider, then the mode picks the multiplier
	always_comb begin
		kk_w = elapsed_s[ST_K] ? FULL : M_W'(k_w);
		case (mode_s[ST_K])
			MODE_GROW:    m_w = kk_w;
			MODE_RELEASE: m_w = FULL - kk_w;
			default:      m_w = FULL;
		endcase
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[ST_Q-1:ST_IN], accept};
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: offsets and tick * interval
			for (int i = 0; i < 3; i++) begin
				neg_s[ST_IN][i] <= d_w[i][CRD_W];
				ad_s1[i]        <= d_w[i][CRD_W] ? nd_w[i][AD_W-1:0] : d_w[i][AD_W-1:0];
			end
			mode_s[ST_IN] <= pos_in.data.mode;
			p_s1          <= P_W'(pos_in.data.current_tick) * P_W'(tbase_q);

			// stage 2: squares, gm * |d|, ramp elapsed
			for (int i = 0; i < 3; i++) begin
				sq_s2[i]       <= SQ_W'(ad_s1[i]) * SQ_W'(ad_s1[i]);
				gad_s[ST_SQ][i] <= GAD_W'(gm_q) * GAD_W'(ad_s1[i]);
			end
			elapsed_s[ST_SQ] <= (ramp_q == '0) || (p_s1 >= P_W'(ramp_q));

			// stage 3: squared radius
			sum_s3         <= SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
			zero_s[ST_SUM] <= (sq_s2[0] | sq_s2[1] | sq_s2[2]) == '0;

			// multiplier for the ramp
			m_s[ST_M] <= m_w;

			// after the root: s = r + a, numerator gm * |d| * m
			r_s37 <= r_w;
			s_s37 <= S_W'(r_w) + S_W'(scale_q);
			for (int i = 0; i < 3; i++)
				num_s37[i] <= NUMP_W'(gad_s[ST_R][i]) * NUMP_W'(m_s[ST_R]);

			// r * s
			rs_s38  <= RS_W'(r_s37) * RS_W'(s_s37);
			s_s38   <= s_s37;
			num_s38 <= num_s37;

			// r * s * s as two partial products
			dlo_s39 <= DLO_W'(rs_s38[RS_LO_W-1:0]) * DLO_W'(s_s38);
			dhi_s39 <= DHI_W'(rs_s38[RS_W-1:RS_LO_W]) * DHI_W'(s_s38);
			num_s39 <= num_s38;

			den_s40 <= DEN_W'(dlo_s39) + (DEN_W'(dhi_s39) << RS_LO_W);
			num_s40 <= num_s39;

			// quotient of 2^48 or more saturates
			for (int i = 0; i < 3; i++)
				ovf_s[ST_OVF][i] <= OVF_W'({num_s40[i], {F{1'b0}}}) >= {den_s40, {ACC_W{1'b0}}};

			// carry sideband along
			for (int t = ST_IN + 1; t <= ST_Q; t++) neg_s[t] <= neg_s[t-1];
			for (int t = ST_IN + 1; t <= ST_K; t++) mode_s[t] <= mode_s[t-1];
			for (int t = ST_SQ + 1; t <= ST_K; t++) elapsed_s[t] <= elapsed_s[t-1];
			for (int t = ST_SQ + 1; t <= ST_R; t++) gad_s[t] <= gad_s[t-1];
			for (int t = ST_SUM + 1; t <= ST_Q; t++) zero_s[t] <= zero_s[t-1];
			for (int t = ST_M + 1; t <= ST_R; t++) m_s[t] <= m_s[t-1];
			for (int t = ST_OVF + 1; t <= ST_Q; t++) ovf_s[t] <= ovf_s[t-1];
		end
	end

	hga_pipe_div #(
		.NUM_W (RN_W),
		.DEN_W (CRD_W),
		.Q_W   (F)
	) u_ramp_div (
		.clk (clk),
		.en  (en),
		.num ({p_s1, {F{1'b0}}}),
		.den (ramp_q),
		.quo (k_w)
	);

	hga_isqrt #(
		.IN_W  (SUM_W),
		.OUT_W (R_W)
	) u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sum_s3),
		.root (r_w)
	);

	for (genvar i = 0; i < 3; i++) begin : g_axis
		hga_pipe_div #(
			.NUM_W (NUM_W),
			.DEN_W (DEN_W),
			.Q_W   (ACC_W)
		) u_div (
			.clk (clk),
			.en  (en),
			.num ({num_s40[i], {F{1'b0}}}),
			.den (den_s40),
			.quo (q_w[i])
		);
	end

	// Saturate, apply sign, zero at the center
	always_comb begin
		logic [ACC_W-1:0] lim;
		logic [ACC_W-1:0] mag;
		for (int i = 0; i < 3; i++) begin
			lim      = neg_s[ST_Q][i] ? ACC_NEG_LIM : ACC_POS_LIM;
			mag      = (ovf_s[ST_Q][i] || (q_w[i] > lim)) ? lim : q_w[i];
			acc_w[i] = zero_s[ST_Q] ? '0 : (neg_s[ST_Q][i] ? -mag : mag);
		end
		res_item.accel_x     = acc_w[0];
		res_item.accel_y     = acc_w[1];
		res_item.accel_z     = acc_w[2];
		res_item.zero_radius = zero_s[ST_Q];
	end

	// Output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Output buffer storage
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= res_item;
	end

	assign acc_out.valid = (cnt_q != '0);
	assign acc_out.data  = fifo_q[rd_q];

	// A halted pipeline keeps every stage valid as it is
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("stage valids moved during a stall");

	// The ramp multiplier never exceeds one
	a_m_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_M] |-> (m_s[ST_M] <= FULL))
		else $error("ramp multiplier above one");

	// A particle at the center yields zero acceleration
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_out.valid && acc_out.data.zero_radius) |->
		(acc_out.data.accel_x == '0 && acc_out.data.accel_y == '0 &&
		 acc_out.data.accel_z == '0))
		else $error("nonzero result at zero radius");

	// The buffer count never passes its depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |=> (cnt_q != 2'd3))
		else $error("output buffer overrun");
endmodule

// ===== tb/hga_checker.sv =====
module hga_checker
	import hga_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pos_valid,
	input  logic      pos_ready,
	input  in_item_t  pos_data,
	input  logic      acc_valid,
	input  logic      acc_ready,
	input  out_item_t acc_data,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  cfg_item_t cfg_data,
	output int        pending,
	output int        errors
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow of the register file
	logic [CRD_W-1:0] center [3];
	logic [CRD_W-1:0] gm;
	logic [CRD_W-1:0] scale;
	logic [CRD_W-1:0] tbase;
	logic [CRD_W-1:0] ramp;

	out_item_t accel_q [$];

	function automatic logic [63:0] tick_mul(logic [31:0] a, logic [31:0] b);
		return 64'(a) * 64'(b);
	endfunction

	// Compute the acceleration result for one particle
	function automatic out_item_t hernquist_accel(in_item_t it);
		logic [CRD_W-1:0] pos [3];
		logic signed [CRD_W:0] d [3];
		logic [127:0] ad [3];
		logic [127:0] sum, p, k, m, r, s, cand, den, num, q, lim, full;
		logic [ACC_W-1:0] mag;
		out_item_t res;
		pos[0] = it.pos_x;
		pos[1] = it.pos_y;
		pos[2] = it.pos_z;
		full = 128'(1) << FRAC_BITS;
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			d[i] = $signed({center[i][CRD_W-1], center[i]}) - $signed({pos[i][CRD_W-1], pos[i]});
			ad[i] = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
			sum = sum + ad[i] * ad[i];
		end
		res = '0;
		if (sum == 0) begin
			res.zero_radius = 1'b1;
			return res;
		end
		// ramp factor, clamped to one
		p = 128'(tick_mul(it.current_tick, tbase));
		if (ramp == 0 || p >= 128'(ramp))
			k = full;
		else
			k = (p << FRAC_BITS) / 128'(ramp);
		if (it.mode == MODE_GROW)
			m = k;
		else if (it.mode == MODE_RELEASE)
			m = full - k;
		else
			m = full;
		// integer square root, one bit at a time
		r = '0;
		for (int b = 34; b >= 0; b--) begin
			cand = r | (128'(1) << b);
			if (cand * cand <= sum)
				r = cand;
		end
		s = r + 128'(scale);
		den = r * s * s;
		for (int i = 0; i < 3; i++) begin
			num = (128'(gm) * ad[i] * m) << FRAC_BITS;
			q = num / den;
			lim = d[i] < 0 ? 128'(ACC_NEG_LIM) : 128'(ACC_POS_LIM);
			mag = q > lim ? lim[ACC_W-1:0] : q[ACC_W-1:0];
			if (d[i] < 0)
				mag = -mag;
			case (i)
				0: res.accel_x = mag;
				1: res.accel_y = mag;
				default: res.accel_z = mag;
			endcase
		end
		return res;
	endfunction

	// Track config writes, predict on input transfers, check output transfers
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			center[0] = CENTER_RESET;
			center[1] = CENTER_RESET;
			center[2] = CENTER_RESET;
			gm = GM_RESET;
			scale = SCALE_RESET;
			tbase = TBASE_RESET;
			ramp = RAMP_RESET;
			accel_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
					REG_CENTER_X:          center[0] = cfg_data.value;
					REG_CENTER_Y:          center[1] = cfg_data.value;
					REG_CENTER_Z:          center[2] = cfg_data.value;
					REG_GM_PRODUCT:        gm = cfg_data.value;
					REG_SCALE_RADIUS:      scale = cfg_data.value;
					REG_TIMEBASE_INTERVAL: tbase = cfg_data.value;
					REG_RAMP_TIME:         ramp = cfg_data.value;
					default: ;
				endcase
			end
			if (pos_valid && pos_ready)
				accel_q.push_back(hernquist_accel(pos_data));
			if (acc_valid && acc_ready) begin
				if (accel_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: %p", acc_data);
				end else begin
					want = accel_q.pop_front();
					if (want.accel_x !== acc_data.accel_x || want.accel_y !== acc_data.accel_y
					    || want.accel_z !== acc_data.accel_z
					    || want.zero_radius !== acc_data.zero_radius) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected x=%h y=%h z=%h zr=%b got x=%h y=%h z=%h zr=%b",
								want.accel_x, want.accel_y, want.accel_z, want.zero_radius,
								acc_data.accel_x, acc_data.accel_y, acc_data.accel_z,
								acc_data.zero_radius);
					end
				end
			end
			pending = accel_q.size();
		end
	end
endmodule

// ===== tb/tb_hernquist_gravity_accel.sv =====
module tb_hernquist_gravity_accel;
	import hga_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 100;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [IDX_W-1:0] IDX_UNUSED = 3'd7;

	logic clk;
	logic arst_n;
	int   pending;
	int   errors;
	int   burst_left;
	int   idle_cnt;
	int   cyc;
	logic [CRD_W-1:0] cen [3];

	hga_stream_if #(.T(in_item_t))  pos_if ();
	hga_stream_if #(.T(out_item_t)) acc_if ();
	hga_stream_if #(.T(cfg_item_t)) cfg_if ();

	hernquist_gravity_accel u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pos_in  (pos_if),
		.acc_out (acc_if),
		.cfg     (cfg_if)
	);

	hga_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.pos_valid (pos_if.valid),
		.pos_ready (pos_if.ready),
		.pos_data  (pos_if.data),
		.acc_valid (acc_if.valid),
		.acc_ready (acc_if.ready),
		.acc_data  (acc_if.data),
		.cfg_valid (cfg_if.valid),
		.cfg_ready (cfg_if.ready),
		.cfg_data  (cfg_if.data),
		.pending   (pending),
		.errors    (errors)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the result side in changing styles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc <= 0;
			acc_if.ready <= 1'b0;
		end else begin
			cyc <= cyc + 1;
			case ((cyc / 300) % 4)
				0: acc_if.ready <= 1'b1;
				1: acc_if.ready <= $urandom_range(0, 1);
				2: acc_if.ready <= ($urandom_range(0, 3) == 0);
				default: acc_if.ready <= cyc[5];
			endcase
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (pos_if.valid && pos_if.ready) || (acc_if.valid && acc_if.ready)
		    || (cfg_if.valid && cfg_if.ready))
			idle_cnt <= 0;
		else begin
			idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Write one register, then drop valid and leave the channel idle
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CRD_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= '{index: idx, value: val};
		do @(negedge clk); while (!cfg_if.ready);
		@(posedge clk);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
		if (idx < 3)
			cen[idx] = val;
	endtask

	// Send one particle, opening a new burst after a random gap
	task automatic send_pos(in_item_t it);
		if (burst_left == 0) begin
			pos_if.valid <= 1'b0;
			repeat ($urandom_range(1, 25)) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
		pos_if.valid <= 1'b1;
		pos_if.data <= it;
		do @(negedge clk); while (!pos_if.ready);
		@(posedge clk);
		burst_left--;
	endtask

	task automatic send(logic [1:0] mode, logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic [31:0] tick);
		in_item_t it;
		it.mode = mode;
		it.pos_x = x;
		it.pos_y = y;
		it.pos_z = z;
		it.current_tick = tick;
		send_pos(it);
	endtask

	// Hold until the pipeline has drained
	task automatic drain();
		pos_if.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_all(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
		logic [31:0] gmv, logic [31:0] sc, logic [31:0] tb, logic [31:0] rt);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		write_reg(REG_GM_PRODUCT, gmv);
		write_reg(REG_SCALE_RADIUS, sc);
		write_reg(REG_TIMEBASE_INTERVAL, tb);
		write_reg(REG_RAMP_TIME, rt);
	endtask

	// Random particle: half near the center, some exactly on it, the rest anywhere
	task automatic send_random();
		logic [31:0] p [3];
		logic [31:0] tick;
		int sel;
		sel = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++) begin
			if (sel < 5)
				p[i] = cen[i] + 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
			else if (sel == 5)
				p[i] = cen[i];
			else
				p[i] = $urandom;
		end
		tick = $urandom_range(0, 1) ? $urandom_range(0, 4096) : $urandom;
		send(2'($urandom_range(0, 3)), p[0], p[1], p[2], tick);
	endtask

	initial begin
		arst_n <= 1'b0;
		pos_if.valid <= 1'b0;
		pos_if.data <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data <= '0;
		burst_left = 0;
		cen[0] = CENTER_RESET;
		cen[1] = CENTER_RESET;
		cen[2] = CENTER_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, particle on the center, extremes, every mode
		send(MODE_UNSCALED, 32'd0, 32'd0, 32'd0, 32'd0);
		send(MODE_UNSCALED, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
		send(MODE_UNSCALED, 32'h80000000, 32'h80000000, 32'h80000000, 32'd0);
		send(MODE_UNSCALED, 32'd1, 32'd0, 32'd0, 32'd5);
		send(MODE_GROW, 32'd65536, 32'hFFFF0000, 32'd3, 32'd7);
		send(MODE_RELEASE, 32'd65536, 32'hFFFF0000, 32'd3, 32'd7);
		send(MODE_SPARE, 32'd65536, 32'hFFFF0000, 32'd3, 32'd7);
		send(MODE_UNSCALED, 32'hFFFFFFFF, 32'd0, 32'd0, 32'd0);
		drain();

		// partial ramp, zero scale radius, largest mass, ignored index
		write_all(32'h00010000, 32'hFFFF0000, 32'd0, 32'hFFFFFFFF, 32'd0, 32'h00000100,
			32'h00100000);
		write_reg(IDX_UNUSED, 32'hDEADBEEF);
		send(MODE_GROW, 32'h00010001, 32'hFFFF0000, 32'd0, 32'd100);
		send(MODE_RELEASE, 32'h00010001, 32'hFFFF0000, 32'd0, 32'd100);
		send(MODE_GROW, 32'h00010000, 32'hFFFF0000, 32'd0, 32'd100);
		send(MODE_GROW, 32'd0, 32'd0, 32'd0, 32'd4096);
		send(MODE_RELEASE, 32'd0, 32'd0, 32'd0, 32'hFFFFFFFF);
		send(MODE_UNSCALED, 32'h00010002, 32'hFFFF0000, 32'd0, 32'd0);
		drain();

		// extreme centers, zero ramp time; no mass with widest scale, then largest mass
		write_all(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'd0, 32'hFFFFFFFF,
			32'hFFFFFFFF, 32'd0);
		send(MODE_GROW, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'd9);
		send(MODE_RELEASE, 32'd0, 32'd0, 32'd0, 32'd9);
		drain();
		write_all(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'd1,
			32'hFFFFFFFF, 32'd0);
		send(MODE_GROW, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'd9);
		send(MODE_UNSCALED, 32'h80000001, 32'h7FFFFFFF, 32'h80000000, 32'd9);
		drain();

		// random phases under random settings
		for (int ph = 0; ph < 6; ph++) begin
			write_all($urandom, $urandom, $urandom,
				$urandom_range(0, 1) ? $urandom : $urandom_range(0, 2 ** 26),
				$urandom_range(0, 1) ? $urandom_range(0, 2 ** 16) : $urandom,
				$urandom_range(0, 1) ? $urandom_range(0, 2 ** 12) : $urandom,
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 2 ** 24));
			repeat (90) send_random();
			drain();
		end

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== sim.f =====
design/hga_pkg.sv
design/hga_stream_if.sv
design/hga_pipe_div.sv
design/hga_isqrt.sv
design/hernquist_gravity_accel.sv
tb/hga_checker.sv
tb/tb_hernquist_gravity_accel.sv
